// ===== rtl/core/jcmi_pkg.sv =====
// jcmi_pkg: shared codes, constants and control/status structs for the
// comment marker inserter; used by jcmi_ctrl, jcmi_dp and the top level
`default_nettype none

package jcmi_pkg;

  // command codes carried on the input tuser
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_COMMENT = 2'd1;
  localparam logic [1:0] CMD_JPEG   = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  // status codes carried on the output tuser
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_END      = 3'd1;
  localparam logic [2:0] ST_NOT_JPEG = 3'd2;
  localparam logic [2:0] ST_SOS      = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;
  localparam logic [2:0] ST_EARLY    = 3'd5;

  // marker bytes
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;
  localparam logic [7:0] MARK_SOS = 8'hDA;
  localparam logic [7:0] MARK_COM = 8'hFE;
  localparam logic [7:0] MARK_DHT = 8'hC4;
  localparam logic [7:0] MARK_JPG = 8'hC8;
  localparam logic [7:0] MARK_DAC = 8'hCC;
  localparam logic [3:0] SOF_HI   = 4'hC;

  // output byte source
  typedef enum logic [3:0] {
    OSEL_IN,
    OSEL_BYTE,
    OSEL_HOLD,
    OSEL_FF,
    OSEL_SOI,
    OSEL_COM,
    OSEL_LEN_HI,
    OSEL_LEN_LO,
    OSEL_MEM,
    OSEL_ZERO
  } osel_e;

  typedef struct packed {
    logic       accept;
    logic       clear_comment;
    logic       append_comment;
    logic       load_hold;
    logic       load_seg;
    logic       dec_seg;
    logic       set_drop;
    logic       clr_drop;
    logic       rd_start;
    logic       rd_next;
    logic       out_load;
    osel_e      out_sel;
    logic [2:0] out_status;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic comment_empty;
    logic dropping;
    logic len_bad_in;
    logic seg_zero_in;
    logic len_bad_q;
    logic seg_last;
    logic body_done;
    logic is_ff;
    logic is_soi;
    logic is_sof_eoi;
    logic is_sos;
    logic is_com;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/jcmi_dp.sv =====
// jcmi_dp: datapath of the comment marker inserter: comment memory, length
// and segment counters, byte classification and the output register
// depends on jcmi_pkg
`default_nettype none

module jcmi_dp
  import jcmi_pkg::*;
#(
  parameter int COMMENT_DEPTH = 56
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] s_axis_tdata_i,
  input  wire ctrl_cmd_t  cmd_i,
  output dp_sts_t         sts_o,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,
  output logic [2:0]      m_axis_tuser_o,
  output logic            m_axis_tlast_o
);

  localparam int CW = $clog2(COMMENT_DEPTH + 1);
  localparam int AW = (COMMENT_DEPTH > 1) ? $clog2(COMMENT_DEPTH) : 1;

  logic [7:0]    mem [COMMENT_DEPTH];
  logic [7:0]    rdata_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [7:0]    hold_q;
  logic [7:0]    byte_q;
  logic [15:0]   seg_q, seg_d;
  logic          drop_q, drop_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q;
  logic [2:0]    out_user_q;
  logic          out_last_q;
  logic          comment_full;
  logic [15:0]   com_len;
  logic [AW-1:0] rd_addr;
  logic [7:0]    out_byte;

  assign comment_full = (count_q == CW'(COMMENT_DEPTH));
  assign com_len      = 16'(count_q) + 16'd2;
  assign rd_addr      = cmd_i.rd_start ? '0 : idx_q[AW-1:0];

  // comment memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_comment && !comment_full) begin
      mem[count_q[AW-1:0]] <= s_axis_tdata_i;
    end
    if (cmd_i.rd_start || cmd_i.rd_next) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear_comment) begin
      count_d = '0;
    end else if (cmd_i.append_comment && !comment_full) begin
      count_d = count_q + CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.rd_start) begin
      idx_d = CW'(1);
    end else if (cmd_i.rd_next) begin
      idx_d = idx_q + CW'(1);
    end
    seg_d = seg_q;
    if (cmd_i.load_seg) begin
      seg_d = {hold_q, s_axis_tdata_i} - 16'd2;
    end else if (cmd_i.dec_seg) begin
      seg_d = seg_q - 16'd1;
    end
    drop_d = drop_q;
    if (cmd_i.set_drop) begin
      drop_d = 1'b1;
    end else if (cmd_i.clr_drop) begin
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      seg_q   <= '0;
      drop_q  <= 1'b0;
      hold_q  <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      seg_q   <= seg_d;
      drop_q  <= drop_d;
      if (cmd_i.load_hold) begin
        hold_q <= s_axis_tdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  // output register
  always_comb begin
    unique case (cmd_i.out_sel)
      OSEL_IN:     out_byte = s_axis_tdata_i;
      OSEL_BYTE:   out_byte = byte_q;
      OSEL_HOLD:   out_byte = hold_q;
      OSEL_FF:     out_byte = BYTE_FF;
      OSEL_SOI:    out_byte = MARK_SOI;
      OSEL_COM:    out_byte = MARK_COM;
      OSEL_LEN_HI: out_byte = com_len[15:8];
      OSEL_LEN_LO: out_byte = com_len[7:0];
      OSEL_MEM:    out_byte = rdata_q;
      OSEL_ZERO:   out_byte = '0;
      default:     out_byte = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_byte;
      out_user_q <= cmd_i.out_status;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // status toward the controller
  always_comb begin
    sts_o.out_free      = !out_valid_q || m_axis_tready_i;
    sts_o.comment_empty = (count_q == '0);
    sts_o.dropping      = drop_q;
    sts_o.len_bad_in    = (hold_q == '0) && (s_axis_tdata_i < 8'd2);
    sts_o.seg_zero_in   = (hold_q == '0) && (s_axis_tdata_i == 8'd2);
    sts_o.len_bad_q     = (hold_q == '0) && (byte_q < 8'd2);
    sts_o.seg_last      = (seg_q == 16'd1);
    sts_o.body_done     = (idx_q == count_q);
    sts_o.is_ff         = (s_axis_tdata_i == BYTE_FF);
    sts_o.is_soi        = (s_axis_tdata_i == MARK_SOI);
    sts_o.is_sof_eoi    = (s_axis_tdata_i == MARK_EOI) ||
                          ((s_axis_tdata_i[7:4] == SOF_HI) &&
                           (s_axis_tdata_i != MARK_DHT) &&
                           (s_axis_tdata_i != MARK_JPG) &&
                           (s_axis_tdata_i != MARK_DAC));
    sts_o.is_sos        = (s_axis_tdata_i == MARK_SOS);
    sts_o.is_com        = (s_axis_tdata_i == MARK_COM);
  end

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_next |-> (idx_q < count_q))
    else $error("comment read past stored count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/jcmi_ctrl.sv =====
// jcmi_ctrl: marker parser and result sequencer of the comment marker
// inserter; drives the datapath through ctrl_cmd_t, depends on jcmi_pkg
`default_nettype none

module jcmi_ctrl
  import jcmi_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [1:0] s_axis_tuser_i,
  input  wire dp_sts_t    sts_i,
  output ctrl_cmd_t       cmd_o
);

  // parse phases
  localparam logic [3:0] PH_FIRST0     = 4'd0;
  localparam logic [3:0] PH_FIRST1_OK  = 4'd1;
  localparam logic [3:0] PH_FIRST1_BAD = 4'd2;
  localparam logic [3:0] PH_SEEK_FF    = 4'd3;
  localparam logic [3:0] PH_MARKER     = 4'd4;
  localparam logic [3:0] PH_LEN_HI     = 4'd5;
  localparam logic [3:0] PH_LEN_LO     = 4'd6;
  localparam logic [3:0] PH_BODY       = 4'd7;
  localparam logic [3:0] PH_PASS       = 4'd8;
  localparam logic [3:0] PH_HALT       = 4'd9;

  // sequencer states
  localparam logic [3:0] SQ_IDLE     = 4'd0;
  localparam logic [3:0] SQ_SOI      = 4'd1;
  localparam logic [3:0] SQ_MARK     = 4'd2;
  localparam logic [3:0] SQ_COM_FE   = 4'd3;
  localparam logic [3:0] SQ_COM_LH   = 4'd4;
  localparam logic [3:0] SQ_COM_LL   = 4'd5;
  localparam logic [3:0] SQ_COM_BODY = 4'd6;
  localparam logic [3:0] SQ_FF2      = 4'd7;
  localparam logic [3:0] SQ_LOBYTE   = 4'd8;
  localparam logic [3:0] SQ_STAT     = 4'd9;

  logic [3:0] phase_q, phase_d;
  logic [3:0] seq_q, seq_d;
  logic       accept;

  assign s_axis_tready_o = (seq_q == SQ_IDLE) && sts_i.out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    phase_d        = phase_q;
    seq_d          = seq_q;
    cmd_o          = '0;
    cmd_o.out_sel  = OSEL_ZERO;
    cmd_o.accept   = accept;

    unique case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser_i)
            CMD_START: begin
              phase_d             = PH_FIRST0;
              cmd_o.clear_comment = 1'b1;
              cmd_o.clr_drop      = 1'b1;
            end
            CMD_COMMENT: begin
              cmd_o.append_comment = 1'b1;
            end
            CMD_END: begin
              if (phase_q != PH_HALT) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                if (phase_q == PH_PASS) begin
                  cmd_o.out_status = ST_END;
                end else if (phase_q == PH_FIRST0 || phase_q == PH_FIRST1_OK ||
                             phase_q == PH_FIRST1_BAD) begin
                  cmd_o.out_status = ST_NOT_JPEG;
                end else begin
                  cmd_o.out_status = ST_EARLY;
                end
                phase_d = PH_HALT;
              end
            end
            CMD_JPEG: begin
              unique case (phase_q)
                PH_FIRST0: begin
                  phase_d = sts_i.is_ff ? PH_FIRST1_OK : PH_FIRST1_BAD;
                end
                PH_FIRST1_OK, PH_FIRST1_BAD: begin
                  cmd_o.out_load = 1'b1;
                  if (phase_q == PH_FIRST1_BAD || !sts_i.is_soi) begin
                    cmd_o.out_status = ST_NOT_JPEG;
                    cmd_o.out_last   = 1'b1;
                    phase_d          = PH_HALT;
                  end else begin
                    cmd_o.out_sel = OSEL_FF;
                    seq_d         = SQ_SOI;
                    phase_d       = PH_SEEK_FF;
                  end
                end
                PH_SEEK_FF: begin
                  if (sts_i.is_ff) begin
                    phase_d = PH_MARKER;
                  end
                end
                PH_MARKER: begin
                  priority if (sts_i.is_ff) begin
                    phase_d = PH_MARKER;
                  end else if (sts_i.is_sof_eoi) begin
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_sel  = OSEL_FF;
                    seq_d          = sts_i.comment_empty ? SQ_MARK : SQ_COM_FE;
                    phase_d        = PH_PASS;
                  end else if (sts_i.is_sos) begin
                    cmd_o.out_load   = 1'b1;
                    cmd_o.out_status = ST_SOS;
                    cmd_o.out_last   = 1'b1;
                    phase_d          = PH_HALT;
                  end else if (sts_i.is_com) begin
                    cmd_o.set_drop = 1'b1;
                    phase_d        = PH_LEN_HI;
                  end else begin
                    cmd_o.clr_drop = 1'b1;
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_sel  = OSEL_FF;
                    seq_d          = SQ_MARK;
                    phase_d        = PH_LEN_HI;
                  end
                end
                PH_LEN_HI: begin
                  cmd_o.load_hold = 1'b1;
                  phase_d         = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                  cmd_o.load_seg = 1'b1;
                  if (!sts_i.dropping) begin
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_sel  = OSEL_HOLD;
                    seq_d          = SQ_LOBYTE;
                  end else if (sts_i.len_bad_in) begin
                    cmd_o.out_load   = 1'b1;
                    cmd_o.out_status = ST_LENGTH;
                    cmd_o.out_last   = 1'b1;
                  end
                  if (sts_i.len_bad_in) begin
                    phase_d = PH_HALT;
                  end else if (sts_i.seg_zero_in) begin
                    phase_d = PH_SEEK_FF;
                  end else begin
                    phase_d = PH_BODY;
                  end
                end
                PH_BODY: begin
                  cmd_o.dec_seg = 1'b1;
                  if (!sts_i.dropping) begin
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_sel  = OSEL_IN;
                    cmd_o.out_last = 1'b1;
                  end
                  if (sts_i.seg_last) begin
                    phase_d = PH_SEEK_FF;
                  end
                end
                PH_PASS: begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_sel  = OSEL_IN;
                  cmd_o.out_last = 1'b1;
                end
                default: begin
                  phase_d = phase_q;
                end
              endcase
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
      SQ_SOI: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_SOI;
          cmd_o.out_last = 1'b1;
          seq_d          = SQ_IDLE;
        end
      end
      SQ_MARK: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_BYTE;
          cmd_o.out_last = 1'b1;
          seq_d          = SQ_IDLE;
        end
      end
      SQ_COM_FE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_COM;
          seq_d          = SQ_COM_LH;
        end
      end
      SQ_COM_LH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_LEN_HI;
          seq_d          = SQ_COM_LL;
        end
      end
      SQ_COM_LL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_LEN_LO;
          cmd_o.rd_start = 1'b1;
          seq_d          = SQ_COM_BODY;
        end
      end
      SQ_COM_BODY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_MEM;
          if (sts_i.body_done) begin
            seq_d = SQ_FF2;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      SQ_FF2: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_FF;
          seq_d          = SQ_MARK;
        end
      end
      SQ_LOBYTE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_BYTE;
          cmd_o.out_last = !sts_i.len_bad_q;
          seq_d          = sts_i.len_bad_q ? SQ_STAT : SQ_IDLE;
        end
      end
      SQ_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_LENGTH;
          cmd_o.out_last   = 1'b1;
          seq_d            = SQ_IDLE;
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST0;
      seq_q   <= SQ_IDLE;
    end else begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
    end
  end

`ifndef SYNTHESIS
  a_body_has_comment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_COM_BODY) |-> !sts_i.comment_empty)
    else $error("comment body sequence with empty comment");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT && seq_q == SQ_IDLE) |-> !cmd_o.out_load)
    else $error("result produced while halted");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_comment_marker_inserter.sv =====
// jpeg_comment_marker_inserter: top level of the comment marker inserter
// instantiates jcmi_ctrl and jcmi_dp, depends on jcmi_pkg
`default_nettype none

// Comment bytes (tuser 1) are stored first, then JPEG bytes (tuser 2) are
// parsed and rewritten; tuser 0 starts a new stream and tuser 3 ends it. The
// output carries rewritten bytes with status 0, or one status word with tlast.
// Every result passes through a single output register, one result per
// cycle while the receiver takes them. A command yields one result or
// none, but a marker pair yields FF and the marker, the header check FF D8,
// a kept length pair both bytes plus a status if under two, and the marker
// that triggers insertion FF FE, the length, the comment memory read out
// one entry per cycle, FF and the marker. Input is held off while a
// multi-result item is emitted or the output register is full and not taken.

module jpeg_comment_marker_inserter
  import jcmi_pkg::*;
#(
  parameter int COMMENT_DEPTH = 56
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // data_byte
  input  wire logic [1:0] s_axis_tuser_i,   // command
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // out_byte
  output logic [2:0]      m_axis_tuser_o,   // status
  output logic            m_axis_tlast_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  jcmi_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  jcmi_dp #(
    .COMMENT_DEPTH (COMMENT_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== verif/jcmi_rewrite_check.sv =====
// jcmi_rewrite_check: watches both stream channels of the comment marker
// inserter, predicts the rewritten stream and compares it transfer by transfer
// depends on jcmi_pkg
`timescale 1ns / 100ps

module jcmi_rewrite_check
  import jcmi_pkg::*;
#(
  parameter int COMMENT_DEPTH = 56
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] in_data_i,
  input  wire logic [1:0] in_cmd_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic [2:0] out_status_i,
  input  wire logic       out_last_i,
  output int              mismatch_count_o,
  output int              outstanding_o
);

  typedef enum logic [3:0] {
    SCAN_SOI_FF,
    SCAN_SOI_OK,
    SCAN_SOI_BAD,
    SCAN_SEEK_FF,
    SCAN_MARKER,
    SCAN_LEN_HI,
    SCAN_LEN_LO,
    SCAN_BODY,
    SCAN_PASS,
    SCAN_HALT
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } rewrite_word_t;

  rewrite_word_t expected_words[$];
  rewrite_word_t item_words[$];
  rewrite_word_t want;
  rewrite_word_t word;

  scan_phase_e phase;
  logic [15:0] seg_left;
  logic [7:0]  len_hi;
  logic        dropping;
  logic [7:0]  comment_mem[COMMENT_DEPTH];
  logic [5:0]  comment_len;
  int          fail_total;

  function automatic void emit_word(input logic [7:0] d, input logic [2:0] st);
    item_words.push_back('{d, st, 1'b0});
  endfunction

  function automatic logic is_frame_start(input logic [7:0] m);
    return m[7:4] == SOF_HI && m != MARK_DHT && m != MARK_JPG && m != MARK_DAC;
  endfunction

  function automatic void restart_stream();
    phase = SCAN_SOI_FF;
    seg_left = '0;
    len_hi = '0;
    dropping = 1'b0;
    comment_len = '0;
  endfunction

  function automatic void rewrite_jpeg_byte(input logic [7:0] b);
    logic [15:0] seg_len;
    logic [15:0] com_len;
    case (phase)
      SCAN_SOI_FF: phase = (b == BYTE_FF) ? SCAN_SOI_OK : SCAN_SOI_BAD;
      SCAN_SOI_OK, SCAN_SOI_BAD: begin
        if (phase == SCAN_SOI_BAD || b != MARK_SOI) begin
          emit_word(8'h00, ST_NOT_JPEG);
          phase = SCAN_HALT;
        end else begin
          emit_word(BYTE_FF, ST_DATA);
          emit_word(MARK_SOI, ST_DATA);
          phase = SCAN_SEEK_FF;
        end
      end
      SCAN_SEEK_FF: if (b == BYTE_FF) phase = SCAN_MARKER;
      SCAN_MARKER: begin
        if (b == BYTE_FF) begin
          // fill byte, stay
        end else if (is_frame_start(b) || b == MARK_EOI) begin
          if (comment_len != 0) begin
            com_len = 16'(comment_len) + 16'd2;
            emit_word(BYTE_FF, ST_DATA);
            emit_word(MARK_COM, ST_DATA);
            emit_word(com_len[15:8], ST_DATA);
            emit_word(com_len[7:0], ST_DATA);
            for (int i = 0; i < comment_len; i++) emit_word(comment_mem[i], ST_DATA);
          end
          emit_word(BYTE_FF, ST_DATA);
          emit_word(b, ST_DATA);
          phase = SCAN_PASS;
        end else if (b == MARK_SOS) begin
          emit_word(8'h00, ST_SOS);
          phase = SCAN_HALT;
        end else if (b == MARK_COM) begin
          dropping = 1'b1;
          phase = SCAN_LEN_HI;
        end else begin
          dropping = 1'b0;
          emit_word(BYTE_FF, ST_DATA);
          emit_word(b, ST_DATA);
          phase = SCAN_LEN_HI;
        end
      end
      SCAN_LEN_HI: begin
        len_hi = b;
        phase = SCAN_LEN_LO;
      end
      SCAN_LEN_LO: begin
        seg_len = {len_hi, b};
        if (!dropping) begin
          emit_word(len_hi, ST_DATA);
          emit_word(b, ST_DATA);
        end
        if (seg_len < 16'd2) begin
          emit_word(8'h00, ST_LENGTH);
          phase = SCAN_HALT;
        end else begin
          seg_left = seg_len - 16'd2;
          phase = (seg_left == 0) ? SCAN_SEEK_FF : SCAN_BODY;
        end
      end
      SCAN_BODY: begin
        if (!dropping) emit_word(b, ST_DATA);
        seg_left = seg_left - 16'd1;
        if (seg_left == 0) phase = SCAN_SEEK_FF;
      end
      SCAN_PASS: emit_word(b, ST_DATA);
      default: ;
    endcase
  endfunction

  function automatic void close_stream();
    if (phase != SCAN_HALT) begin
      if (phase == SCAN_PASS) emit_word(8'h00, ST_END);
      else if (phase inside {SCAN_SOI_FF, SCAN_SOI_OK, SCAN_SOI_BAD})
        emit_word(8'h00, ST_NOT_JPEG);
      else emit_word(8'h00, ST_EARLY);
      phase = SCAN_HALT;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      restart_stream();
      expected_words.delete();
      fail_total = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          if (fail_total < 10)
            $display("%0t: unexpected transfer: byte %02h status %0d last %0b",
                     $realtime, out_byte_i, out_status_i, out_last_i);
          fail_total++;
        end else begin
          want = expected_words.pop_front();
          if (want.data != out_byte_i || want.status != out_status_i ||
              want.last != out_last_i) begin
            if (fail_total < 10)
              $display("%0t: mismatch: expected %02h/%0d/%0b got %02h/%0d/%0b",
                       $realtime, want.data, want.status, want.last,
                       out_byte_i, out_status_i, out_last_i);
            fail_total++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        item_words.delete();
        case (in_cmd_i)
          CMD_START: restart_stream();
          CMD_COMMENT: begin
            if (comment_len < COMMENT_DEPTH) begin
              comment_mem[comment_len] = in_data_i;
              comment_len = comment_len + 6'd1;
            end
          end
          CMD_JPEG: rewrite_jpeg_byte(in_data_i);
          default: close_stream();
        endcase
        foreach (item_words[k]) begin
          word = item_words[k];
          word.last = (k == item_words.size() - 1);
          expected_words.push_back(word);
        end
      end
    end
    outstanding_o <= expected_words.size();
    mismatch_count_o <= fail_total;
  end

endmodule

// ===== verif/jpeg_comment_marker_inserter_test.sv =====
// jpeg_comment_marker_inserter_test: drives command and byte streams into the
// comment marker inserter with random idling on both sides
// depends on jcmi_pkg, jpeg_comment_marker_inserter and jcmi_rewrite_check
`timescale 1ns / 100ps

module jpeg_comment_marker_inserter_test
  import jcmi_pkg::*;
();

  localparam int COMMENT_DEPTH = 56;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 190;

  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] MARK_DQT  = 8'hDB;
  localparam logic [7:0] MARK_SOF0 = {SOF_HI, 4'h0};

  typedef enum int {
    FAULT_NONE,
    FAULT_OPEN,
    FAULT_HEADER,
    FAULT_SOS,
    FAULT_LENGTH,
    FAULT_EARLY
  } stream_fault_e;

  logic       clk;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [1:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  bit hold_req = 1'b0;

  jpeg_comment_marker_inserter #(
    .COMMENT_DEPTH(COMMENT_DEPTH)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  jcmi_rewrite_check #(
    .COMMENT_DEPTH(COMMENT_DEPTH)
  ) rewrite_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (s_tvalid),
    .in_ready_i      (s_tready),
    .in_data_i       (s_tdata),
    .in_cmd_i        (s_tuser),
    .out_valid_i     (m_tvalid),
    .out_ready_i     (m_tready),
    .out_byte_i      (m_tdata),
    .out_status_i    (m_tuser),
    .out_last_i      (m_tlast),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin
    int tick;
    int mode;
    m_tready <= 1'b0;
    tick = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= tick[2];
        endcase
      end
    end
  end

  task automatic put_item(input logic [1:0] cmd, input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_segment_marker();
    case ($urandom_range(0, 5))
      0: return MARK_COM;
      1: return MARK_DHT;
      2: return {4'hE, 4'($urandom)};
      3: return $urandom_range(0, 1) ? MARK_JPG : MARK_DAC;
      4: return MARK_DQT;
      default: return 8'($urandom_range(0, 8'hBF));
    endcase
  endfunction

  function automatic logic [7:0] pick_trigger_marker();
    logic [7:0] m;
    if ($urandom_range(0, 3) == 0) return MARK_EOI;
    do m = {SOF_HI, 4'($urandom)}; while (m == MARK_DHT || m == MARK_JPG || m == MARK_DAC);
    return m;
  endfunction

  task automatic send_stream(input int comment_bytes, input int segments,
                             input int pass_bytes, input stream_fault_e fault,
                             input bit hold);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] seg_len;
    int          depth;
    put_item(CMD_START, 8'($urandom));
    repeat (comment_bytes) put_item(CMD_COMMENT, 8'($urandom));
    if (fault == FAULT_HEADER) begin
      depth = $urandom_range(0, 2);
      b0 = $urandom_range(0, 1) ? BYTE_FF : 8'($urandom);
      b1 = $urandom_range(0, 1) ? MARK_SOI : 8'($urandom);
      if (b0 == BYTE_FF && b1 == MARK_SOI) b1 = ~MARK_SOI;
      if (depth >= 1) put_item(CMD_JPEG, b0);
      if (depth >= 2) put_item(CMD_JPEG, b1);
      put_item(CMD_END, 8'($urandom));
      put_item(CMD_JPEG, 8'($urandom));
      return;
    end
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_SOI);
    for (int s = 0; s < segments; s++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) put_item(CMD_JPEG, 8'($urandom_range(0, 254)));
      put_item(CMD_JPEG, BYTE_FF);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
        put_item(CMD_JPEG, BYTE_FF);
      put_item(CMD_JPEG, pick_segment_marker());
      seg_len = 16'($urandom_range(2, 7));
      put_item(CMD_JPEG, seg_len[15:8]);
      put_item(CMD_JPEG, seg_len[7:0]);
      repeat (seg_len - 2) put_item(CMD_JPEG, 8'($urandom));
    end
    case (fault)
      FAULT_SOS: begin
        put_item(CMD_JPEG, BYTE_FF);
        if ($urandom_range(0, 1)) put_item(CMD_JPEG, BYTE_FF);
        put_item(CMD_JPEG, MARK_SOS);
        put_item(CMD_END, 8'($urandom));
      end
      FAULT_LENGTH: begin
        put_item(CMD_JPEG, BYTE_FF);
        put_item(CMD_JPEG, pick_segment_marker());
        put_item(CMD_JPEG, 8'h00);
        put_item(CMD_JPEG, 8'($urandom_range(0, 1)));
        put_item(CMD_END, 8'($urandom));
      end
      FAULT_EARLY: begin
        depth = $urandom_range(0, 3);
        if (depth >= 1) put_item(CMD_JPEG, BYTE_FF);
        if (depth >= 2) begin
          put_item(CMD_JPEG, pick_segment_marker());
          put_item(CMD_JPEG, 8'h00);
        end
        if (depth >= 3) begin
          put_item(CMD_JPEG, 8'h09);
          repeat (2) put_item(CMD_JPEG, 8'($urandom));
        end
        put_item(CMD_END, 8'($urandom));
      end
      default: begin
        if (hold) hold_req = 1'b1;
        put_item(CMD_JPEG, BYTE_FF);
        put_item(CMD_JPEG, pick_trigger_marker());
        repeat (pass_bytes) put_item(CMD_JPEG, 8'($urandom));
        if (fault != FAULT_OPEN) put_item(CMD_END, 8'($urandom));
      end
    endcase
  endtask

  initial begin
    int base;
    stream_fault_e fault;
    rst_n <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    s_tuser <= CMD_START;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end before any stream, then a byte while halted
    put_item(CMD_END, 8'h00);
    put_item(CMD_JPEG, BYTE_FF);
    // two-byte comment, garbage, dropped comment segment, fill byte, frame start
    put_item(CMD_START, BYTE_FF);
    put_item(CMD_COMMENT, 8'h00);
    put_item(CMD_COMMENT, BYTE_FF);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_SOI);
    put_item(CMD_JPEG, 8'h12);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_COM);
    put_item(CMD_JPEG, 8'h00);
    put_item(CMD_JPEG, 8'h03);
    put_item(CMD_JPEG, 8'hAA);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_SOF0);
    put_item(CMD_JPEG, 8'h55);
    put_item(CMD_END, BYTE_FF);
    // length under two
    put_item(CMD_START, 8'h00);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_SOI);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_APP0);
    put_item(CMD_JPEG, 8'h00);
    put_item(CMD_JPEG, 8'h01);
    // scan before frame
    put_item(CMD_START, 8'h00);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_SOI);
    put_item(CMD_JPEG, BYTE_FF);
    put_item(CMD_JPEG, MARK_SOS);
    drain();

    // full comment store with overflow, output held off so input backs up
    send_stream(60, 2, 50, FAULT_NONE, 1'b1);
    drain();

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          fault = ($urandom_range(0, 5) == 0) ? FAULT_OPEN : FAULT_NONE;
          send_stream($urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 8),
                      fault, 1'b0);
        end
        6, 7: begin
          case ($urandom_range(0, 3))
            0: fault = FAULT_HEADER;
            1: fault = FAULT_SOS;
            2: fault = FAULT_LENGTH;
            default: fault = FAULT_EARLY;
          endcase
          send_stream($urandom_range(0, 4), $urandom_range(0, 2), 0, fault, 1'b0);
        end
        8: repeat ($urandom_range(4, 12))
             put_item(2'($urandom_range(0, 3)), 8'($urandom));
        default: send_stream($urandom_range(54, 60), $urandom_range(0, 2),
                             $urandom_range(0, 4), FAULT_NONE, 1'b0);
      endcase
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
